// ===== hw/rtl/ipap_pkg.sv =====
// ----------------------------------------------------------------------------
// ipap_pkg: shared types and constants for the address text parser
// Parse phases, status codes, character codes, result and push bundles.
// ----------------------------------------------------------------------------
package ipap_pkg;

  typedef enum logic [2:0] {
    PH_START,
    PH_V4,
    PH_LEAD,
    PH_GSTART,
    PH_AFTERGAP,
    PH_GROUP,
    PH_SKIP
  } phase_t;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_FAMILY    = 2'd2;

  localparam logic [1:0] FAM_V4 = 2'd0;
  localparam logic [1:0] FAM_V6 = 2'd1;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_CASE  = 8'h20;

  localparam int OCTET_MAX = 255;
  localparam logic [2:0] GRP_LAST  = 3'd7;
  localparam logic [2:0] GRP_EMBED = 3'd6;
  localparam logic [1:0] OCT_LAST  = 2'd3;

  localparam int OFIFO_DEPTH = 4;
  localparam int OFIFO_AW    = $clog2(OFIFO_DEPTH);
  localparam int OFIFO_CW    = OFIFO_AW + 1;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] addr_word;
    logic        last;
  } res_t;

  // zero, one or two results written into the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  // {valid, value} of a hex digit, either case
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] lc;
    lc = c | CH_CASE;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      return {1'b1, 4'(c - CH_ZERO)};
    end else if (lc >= CH_LA && lc <= CH_LF) begin
      return {1'b1, 4'(lc - CH_LA + 8'd10)};
    end else begin
      return 5'd0;
    end
  endfunction

endpackage

// ===== hw/rtl/ipap_if.sv =====
// ----------------------------------------------------------------------------
// ipap_if: valid/ready channels of the address text parser
// Character input channel and result output channel.
// ----------------------------------------------------------------------------
interface ipap_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic [1:0] address_family;

  modport source (output valid, output char_code, output address_family, input ready);
  modport sink   (input valid, input char_code, input address_family, output ready);
endinterface

interface ipap_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [63:0] addr_word;
  logic        last;

  modport source (output valid, output status, output addr_word, output last, input ready);
  modport sink   (input valid, input status, input addr_word, input last, output ready);
endinterface

// ===== hw/rtl/ip_address_text_parser.sv =====
// ----------------------------------------------------------------------------
// ip_address_text_parser: IPv4 / IPv6 address text parser
// Parses address text one character per beat and reports status and address.
// ----------------------------------------------------------------------------
// Results: a terminating NUL beat writes its result or results into the queue;
//   the low half of an IPv6 address is queued behind the high half.
// Throughput: one character per cycle; the input register advances whenever
//   the four-entry result queue has room for two results.
// Reset: synchronous, active low; parse state returns to string start and
//   the queue empties.
module ip_address_text_parser import ipap_pkg::*; (
  input logic         clk,
  input logic         rst_n,
  ipap_in_if.sink     in_ch,
  ipap_out_if.source  out_ch
);

  logic       iv_r;
  logic [7:0] ichar_r;
  logic [1:0] ifam_r;
  logic       room;
  logic       step;
  logic       take;
  push_t      push;
  res_t       res;

  assign step         = iv_r && room;
  assign in_ch.ready  = !iv_r || room;
  assign take         = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (take) begin
      iv_r <= 1'b1;
    end else if (step) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ichar_r <= in_ch.char_code;
      ifam_r  <= in_ch.address_family;
    end
  end

  ipap_parse u_parse (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .char_code      (ichar_r),
    .address_family (ifam_r),
    .push           (push)
  );

  ipap_ofifo u_ofifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .room  (room),
    .valid (out_ch.valid),
    .ready (out_ch.ready),
    .data  (res)
  );

  assign out_ch.status    = res.status;
  assign out_ch.addr_word = res.addr_word;
  assign out_ch.last      = res.last;

endmodule

// ===== hw/rtl/ipap_parse.sv =====
// ----------------------------------------------------------------------------
// ipap_parse: per-character parse step
// Holds the parse state and turns one character into zero, one or two results.
// ----------------------------------------------------------------------------
module ipap_parse import ipap_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] char_code,
  input  logic [1:0] address_family,
  output push_t      push
);

  // groups before the gap sit at their index; groups after it shift into tail
  logic [15:0] head_r [8];
  logic [15:0] head_nxt [8];
  logic [15:0] tail_r [8];
  logic [15:0] tail_nxt [8];
  logic [7:0]  oct_r [4];
  logic [7:0]  oct_nxt [4];
  logic [2:0]  gidx_r, gidx_nxt;
  logic        gap_vld_r, gap_vld_nxt;
  logic [2:0]  gap_pos_r, gap_pos_nxt;
  logic [15:0] hex_r, hex_nxt;
  logic [7:0]  dec_r, dec_nxt;
  logic        dec_bad_r, dec_bad_nxt;
  logic [2:0]  dcnt_r, dcnt_nxt;
  logic        fdz_r, fdz_nxt;
  logic [1:0]  oidx_r, oidx_nxt;
  phase_t      phase_r, phase_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        fam_v4_r, fam_v4_nxt;

  phase_t      ph;
  logic        hold;
  logic [1:0]  err_c;
  logic        fam_v4_c;
  logic        hv;
  logic [3:0]  hd;
  logic        is_dig;
  logic [11:0] dec_mul;
  logic        fail;
  logic        emit6;
  logic [15:0] head_f [8];
  logic [15:0] tail_f [8];
  logic [15:0] w [8];
  logic [63:0] v6_hi, v6_lo;

  assign {hv, hd} = hex_digit(char_code);
  assign is_dig   = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
  assign dec_mul  = 12'({dec_r, 3'b000}) + 12'({dec_r, 1'b0}) + 12'(hd);

  // family sample on the first character of a string
  always_comb begin
    ph       = phase_r;
    hold     = 1'b0;
    err_c    = err_r;
    fam_v4_c = fam_v4_r;
    if (phase_r == PH_START) begin
      fam_v4_c = (address_family == FAM_V4);
      if (address_family == FAM_V4) begin
        ph = PH_V4;
      end else if (address_family != FAM_V6) begin
        err_c = ST_FAMILY;
        ph    = PH_SKIP;
      end else if (char_code == CH_COLON) begin
        ph   = PH_LEAD;
        hold = 1'b1;
      end else begin
        ph = PH_GSTART;
      end
    end
  end

  // IPv6 word assembly with gap expansion
  always_comb begin
    for (int p = 0; p < 8; p++) begin
      head_f[p] = (ph == PH_GROUP && !gap_vld_r && gidx_r == 3'(p)) ? hex_r : head_r[p];
    end
    if (ph == PH_GROUP && gap_vld_r) begin
      for (int k = 0; k < 7; k++) begin
        tail_f[k] = tail_r[k+1];
      end
      tail_f[7] = hex_r;
    end else begin
      tail_f = tail_r;
    end
    for (int p = 0; p < 8; p++) begin
      w[p] = (gap_vld_r && 3'(p) >= gap_pos_r) ? tail_f[p] : head_f[p];
    end
    if (ph == PH_V4) begin
      w[6] = {oct_r[0], oct_r[1]};
      w[7] = {oct_r[2], dec_r};
    end
    v6_hi = {w[0], w[1], w[2], w[3]};
    v6_lo = {w[4], w[5], w[6], w[7]};
  end

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    oct_nxt     = oct_r;
    gidx_nxt    = gidx_r;
    gap_vld_nxt = gap_vld_r;
    gap_pos_nxt = gap_pos_r;
    hex_nxt     = hex_r;
    dec_nxt     = dec_r;
    dec_bad_nxt = dec_bad_r;
    dcnt_nxt    = dcnt_r;
    fdz_nxt     = fdz_r;
    oidx_nxt    = oidx_r;
    phase_nxt   = ph;
    err_nxt     = err_c;
    fam_v4_nxt  = fam_v4_c;
    fail        = 1'b0;
    emit6       = 1'b0;
    push        = '0;

    if (hold) begin
      phase_nxt = PH_LEAD;
    end else if (char_code == CH_NUL) begin
      push.cnt = 2'd1;
      push.r0  = '{status: ST_MALFORMED, addr_word: 64'd0, last: 1'b1};
      case (ph)
        PH_SKIP: begin
          push.r0.status = err_c;
        end
        PH_V4: begin
          if (dcnt_r != 3'd0 && oidx_r == OCT_LAST) begin
            if (fam_v4_c) begin
              push.r0.status    = ST_OK;
              push.r0.addr_word = {32'd0, oct_r[0], oct_r[1], oct_r[2], dec_r};
            end else begin
              emit6 = 1'b1;
            end
          end
        end
        PH_GROUP: begin
          if (gap_vld_r || gidx_r == GRP_LAST) begin
            emit6 = 1'b1;
          end
        end
        PH_AFTERGAP: begin
          emit6 = 1'b1;
        end
        default: begin
        end
      endcase
      if (emit6) begin
        push.cnt = 2'd2;
        push.r0  = '{status: ST_OK, addr_word: v6_hi, last: 1'b0};
        push.r1  = '{status: ST_OK, addr_word: v6_lo, last: 1'b1};
      end
      // back to string start
      for (int k = 0; k < 8; k++) begin
        tail_nxt[k] = 16'd0;
      end
      gidx_nxt    = 3'd0;
      gap_vld_nxt = 1'b0;
      gap_pos_nxt = 3'd0;
      hex_nxt     = 16'd0;
      dec_nxt     = 8'd0;
      dec_bad_nxt = 1'b0;
      dcnt_nxt    = 3'd0;
      fdz_nxt     = 1'b0;
      oidx_nxt    = 2'd0;
      phase_nxt   = PH_START;
      err_nxt     = ST_OK;
      fam_v4_nxt  = 1'b1;
    end else begin
      case (ph)
        PH_V4: begin
          if (is_dig) begin
            if (dcnt_r >= 3'd3 || (dcnt_r != 3'd0 && fdz_r)) begin
              fail = 1'b1;
            end else begin
              if (dcnt_r == 3'd0) begin
                fdz_nxt = (char_code == CH_ZERO);
              end
              dec_nxt  = dec_mul[7:0];
              dcnt_nxt = dcnt_r + 3'd1;
              if (dec_mul > 12'(OCTET_MAX)) begin
                fail = 1'b1;
              end
            end
          end else if (char_code == CH_DOT && dcnt_r != 3'd0 && oidx_r != OCT_LAST) begin
            oct_nxt[oidx_r] = dec_r;
            oidx_nxt        = oidx_r + 2'd1;
            dcnt_nxt        = 3'd0;
            dec_nxt         = 8'd0;
            fdz_nxt         = 1'b0;
          end else begin
            fail = 1'b1;
          end
        end
        PH_LEAD: begin
          // second colon of a leading gap
          if (char_code == CH_COLON) begin
            gap_vld_nxt = 1'b1;
            gap_pos_nxt = gidx_r;
            phase_nxt   = PH_AFTERGAP;
          end else begin
            fail = 1'b1;
          end
        end
        PH_GSTART, PH_AFTERGAP: begin
          if (ph == PH_AFTERGAP) begin
            if (gap_pos_r == GRP_LAST) begin
              fail = 1'b1;
            end else begin
              gidx_nxt = gap_pos_r + 3'd1;
            end
          end
          if (!fail) begin
            if (char_code == CH_COLON) begin
              if (!gap_vld_r) begin
                gap_vld_nxt = 1'b1;
                gap_pos_nxt = gidx_r;
                phase_nxt   = PH_AFTERGAP;
              end else begin
                fail = 1'b1;
              end
            end else if (!hv) begin
              fail = 1'b1;
            end else begin
              hex_nxt     = {12'd0, hd};
              dcnt_nxt    = 3'd1;
              fdz_nxt     = (char_code == CH_ZERO);
              dec_nxt     = {4'd0, hd};
              dec_bad_nxt = !is_dig;
              phase_nxt   = PH_GROUP;
            end
          end
        end
        PH_GROUP: begin
          if (char_code == CH_COLON) begin
            if (gidx_r == GRP_LAST) begin
              fail = 1'b1;
            end else begin
              if (gap_vld_r) begin
                for (int k = 0; k < 7; k++) begin
                  tail_nxt[k] = tail_r[k+1];
                end
                tail_nxt[7] = hex_r;
              end else begin
                head_nxt[gidx_r] = hex_r;
              end
              gidx_nxt  = gidx_r + 3'd1;
              phase_nxt = PH_GSTART;
            end
          end else if (char_code == CH_DOT) begin
            if (gidx_r == GRP_LAST || (gidx_r < GRP_EMBED && !gap_vld_r) ||
                dcnt_r > 3'd3 || dec_bad_r || (dcnt_r > 3'd1 && fdz_r)) begin
              fail = 1'b1;
            end else begin
              // group and the slot after it give way to the embedded quad
              if (gap_vld_r) begin
                for (int k = 0; k < 6; k++) begin
                  tail_nxt[k] = tail_r[k+2];
                end
                tail_nxt[6] = hex_r;
                tail_nxt[7] = 16'd0;
              end else begin
                head_nxt[gidx_r] = hex_r;
              end
              gidx_nxt    = gidx_r + 3'd1;
              oct_nxt[0]  = dec_r;
              oidx_nxt    = 2'd1;
              dcnt_nxt    = 3'd0;
              dec_nxt     = 8'd0;
              dec_bad_nxt = 1'b0;
              fdz_nxt     = 1'b0;
              phase_nxt   = PH_V4;
            end
          end else if (!hv || dcnt_r >= 3'd4) begin
            fail = 1'b1;
          end else begin
            hex_nxt  = {hex_r[11:0], hd};
            dcnt_nxt = dcnt_r + 3'd1;
            if (!is_dig || dec_bad_r || dec_mul > 12'(OCTET_MAX)) begin
              dec_bad_nxt = 1'b1;
            end else begin
              dec_nxt = dec_mul[7:0];
            end
          end
        end
        default: begin
        end
      endcase
      if (fail) begin
        err_nxt   = ST_MALFORMED;
        phase_nxt = PH_SKIP;
      end
    end

    if (!step) begin
      push.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 8; k++) begin
        tail_r[k] <= 16'd0;
      end
      gidx_r    <= 3'd0;
      gap_vld_r <= 1'b0;
      gap_pos_r <= 3'd0;
      hex_r     <= 16'd0;
      dec_r     <= 8'd0;
      dec_bad_r <= 1'b0;
      dcnt_r    <= 3'd0;
      fdz_r     <= 1'b0;
      oidx_r    <= 2'd0;
      phase_r   <= PH_START;
      err_r     <= ST_OK;
      fam_v4_r  <= 1'b1;
    end else if (step) begin
      tail_r    <= tail_nxt;
      gidx_r    <= gidx_nxt;
      gap_vld_r <= gap_vld_nxt;
      gap_pos_r <= gap_pos_nxt;
      hex_r     <= hex_nxt;
      dec_r     <= dec_nxt;
      dec_bad_r <= dec_bad_nxt;
      dcnt_r    <= dcnt_nxt;
      fdz_r     <= fdz_nxt;
      oidx_r    <= oidx_nxt;
      phase_r   <= phase_nxt;
      err_r     <= err_nxt;
      fam_v4_r  <= fam_v4_nxt;
    end
  end

  // every entry read here is written earlier in the same string
  always_ff @(posedge clk) begin
    if (step) begin
      head_r <= head_nxt;
      oct_r  <= oct_nxt;
    end
  end

endmodule

// ===== hw/rtl/ipap_ofifo.sv =====
// ----------------------------------------------------------------------------
// ipap_ofifo: result queue
// Small register queue that takes up to two results a cycle, gives one while ready.
// ----------------------------------------------------------------------------
module ipap_ofifo import ipap_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  output logic  room,
  output logic  valid,
  input  logic  ready,
  output res_t  data
);

  res_t                mem_r [OFIFO_DEPTH];
  logic [OFIFO_AW-1:0] wr_r, wr_nxt, wr_r1;
  logic [OFIFO_AW-1:0] rd_r, rd_nxt;
  logic [OFIFO_CW-1:0] cnt_r, cnt_nxt;
  logic                pop;

  assign valid  = (cnt_r != '0);
  assign data   = mem_r[rd_r];
  assign pop    = valid && ready;
  // room for a two-result beat
  assign room   = (cnt_r <= OFIFO_CW'(OFIFO_DEPTH - 2));
  assign wr_r1  = wr_r + OFIFO_AW'(1);
  assign wr_nxt = wr_r + OFIFO_AW'(push.cnt);
  assign rd_nxt = pop ? rd_r + OFIFO_AW'(1) : rd_r;
  assign cnt_nxt = cnt_r + OFIFO_CW'(push.cnt) - OFIFO_CW'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      mem_r[wr_r] <= push.r0;
    end
    if (push.cnt == 2'd2) begin
      mem_r[wr_r1] <= push.r1;
    end
  end

endmodule

// ===== hw/rtl/ipap_chk.sv =====
// ----------------------------------------------------------------------------
// ipap_chk: port checks for the address text parser
// Watches the result channel and is bound to the top level.
// ----------------------------------------------------------------------------
module ipap_chk import ipap_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_status,
  input logic [63:0] out_addr_word,
  input logic        out_last
);

  // high half of an IPv6 address taken, low half still owed
  logic mid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      mid_r <= !out_last;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_addr_word) && $stable(out_last))
    else $error("result beat changed while stalled");

  a_fail_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last && out_addr_word == 64'd0)
    else $error("failed string must give one zero result");

  a_low_half: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mid_r |-> out_status == ST_OK && out_last)
    else $error("high half not followed by an ok last beat");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind ip_address_text_parser ipap_chk u_ipap_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_status    (out_ch.status),
  .out_addr_word (out_ch.addr_word),
  .out_last      (out_ch.last)
);
